// ----- src/hmq_pkg.sv -----
// Shared constants, codes and payload types of the binary min-heap queue.
package hmq_pkg;

  localparam int unsigned HEAP_DEPTH = 1024;
  localparam int unsigned IDX_W      = $clog2(HEAP_DEPTH);
  localparam int unsigned CNT_W      = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned CH_W       = IDX_W + 1;

  localparam int unsigned KIND_W   = 2;
  localparam int unsigned KEY_W    = 24;
  localparam int unsigned ID_W     = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned FILL_W   = 11;
  localparam int unsigned ENTRY_W  = KEY_W + ID_W;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT  = 2'd0,
    KIND_EXTRACT = 2'd1,
    KIND_CLEAR   = 2'd2
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  key;
    logic [ID_W-1:0]   item_id;
  } hmq_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    out_key;
    logic [ID_W-1:0]     out_id;
    logic [FILL_W-1:0]   fill_level;
  } hmq_out_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [ID_W-1:0]  id;
  } heap_entry_t;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    heap_entry_t       wdata;
    logic              re;
    logic [IDX_W-1:0]  raddr;
  } mem_req_t;

endpackage

// ----- src/binary_min_heap_queue.sv -----
// Top level of the binary min-heap priority queue: heap memory and sequencer.
//
//   Channel  Valid        Stall        Payload
//   input    in_valid_i   in_stall_o   in_i  (kind, key, item_id)
//   output   out_valid_o  out_stall_i  out_o (status, out_key, out_id, fill_level)
//
// One item is worked on at a time; the next item is taken once the current one has finished.
// An insert reads one parent per level that the new entry climbs (no read on an empty
// heap); an extract reads the root and the last entry, then the children of each level that
// the moved entry sinks, in turn through the single read port of the heap memory.
// A clear, an item on a full or empty heap, or an unused kind goes straight to the result.
// Reset clears the state, the entry count, the output valid and the output register, and a
// result waits in the output register while the output is stalled.
module binary_min_heap_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  hmq_pkg::hmq_in_t  in_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output hmq_pkg::hmq_out_t out_o
);
  import hmq_pkg::*;

  mem_req_t         mem_req;
  heap_entry_t      mem_rdata;
  logic [ENTRY_W-1:0] rdata_raw;

  // The sequencer keeps the entry being sifted in a register and moves the
  // other entries past it, so each level costs its parent or child reads and a single write.
  hmq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  // Heap array: one entry per slot, key above identifier.
  hmq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (HEAP_DEPTH)
  ) u_heap_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (rdata_raw)
  );

  assign mem_rdata = heap_entry_t'(rdata_raw);

endmodule

// ----- src/hmq_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
module hmq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/hmq_ctrl.sv -----
// Sequencer of the heap: insert sift-up, extract sift-down, clear and result register.
module hmq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  hmq_pkg::hmq_in_t  in_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output hmq_pkg::hmq_out_t out_o,
  output hmq_pkg::mem_req_t mem_req_o,
  input  hmq_pkg::heap_entry_t mem_rdata_i
);
  import hmq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_PLACE,
    S_EX_ROOT,
    S_EX_LAST,
    S_EX_L,
    S_EX_R,
    S_DONE
  } state_e;

  state_e      state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic        out_valid_q, out_valid_d;
  hmq_out_t    out_q, out_d;

  logic [IDX_W-1:0] idx_q, idx_d;
  heap_entry_t cur_q, cur_d;
  heap_entry_t left_q, left_d;
  heap_entry_t root_q, root_d;
  status_e     status_q, status_d;

  mem_req_t    req;

  // Sift-down decision signals.
  heap_entry_t      dec_left;
  logic             dec_rv;
  logic             pick_l, pick_r;
  logic [KEY_W-1:0] best_key;
  logic [CH_W-1:0]  l_ch, r_ch, nl_ch;
  logic [IDX_W-1:0] c_idx, p_idx;
  heap_entry_t      c_ent;

  function automatic logic [IDX_W-1:0] parent_of(input logic [IDX_W-1:0] i);
    return (i - IDX_W'(1)) >> 1;
  endfunction

  always_comb begin
    l_ch     = {idx_q, 1'b1};
    r_ch     = l_ch + CH_W'(1);
    p_idx    = parent_of(idx_q);
    dec_left = (state_q == S_EX_R) ? left_q : mem_rdata_i;
    dec_rv   = (state_q == S_EX_R);
    pick_l   = dec_left.key < cur_q.key;
    best_key = pick_l ? dec_left.key : cur_q.key;
    pick_r   = dec_rv && (mem_rdata_i.key < best_key);
    if (pick_r) begin
      c_ent = mem_rdata_i;
      c_idx = r_ch[IDX_W-1:0];
    end else begin
      c_ent = dec_left;
      c_idx = l_ch[IDX_W-1:0];
    end
    nl_ch = {c_idx, 1'b1};
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    idx_d       = idx_q;
    cur_d       = cur_q;
    left_d      = left_q;
    root_d      = root_q;
    status_d    = status_q;
    req         = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          root_d   = '0;
          status_d = ST_DONE;
          state_d  = S_DONE;
          if (in_i.kind == KIND_INSERT) begin
            if (count_q >= CNT_W'(HEAP_DEPTH)) begin
              status_d = ST_FULL;
            end else begin
              cur_d   = '{key: in_i.key, id: in_i.item_id};
              idx_d   = IDX_W'(count_q);
              count_d = count_q + CNT_W'(1);
              if (count_q == '0) begin
                req.we    = 1'b1;
                req.waddr = '0;
                req.wdata = '{key: in_i.key, id: in_i.item_id};
              end else begin
                req.re    = 1'b1;
                req.raddr = parent_of(IDX_W'(count_q));
                state_d   = S_INS;
              end
            end
          end else if (in_i.kind == KIND_EXTRACT) begin
            if (count_q == '0) begin
              status_d = ST_EMPTY;
            end else begin
              req.re    = 1'b1;
              req.raddr = '0;
              count_d   = count_q - CNT_W'(1);
              state_d   = S_EX_ROOT;
            end
          end else if (in_i.kind == KIND_CLEAR) begin
            count_d = '0;
          end
        end
      end

      S_INS: begin
        req.we = 1'b1;
        if (mem_rdata_i.key > cur_q.key) begin
          // Parent moves down into the hole; the hole climbs one level.
          req.waddr = idx_q;
          req.wdata = mem_rdata_i;
          idx_d     = p_idx;
          if (p_idx == '0) begin
            state_d = S_PLACE;
          end else begin
            req.re    = 1'b1;
            req.raddr = parent_of(p_idx);
          end
        end else begin
          req.waddr = idx_q;
          req.wdata = cur_q;
          state_d   = S_DONE;
        end
      end

      S_PLACE: begin
        req.we    = 1'b1;
        req.waddr = idx_q;
        req.wdata = cur_q;
        state_d   = S_DONE;
      end

      S_EX_ROOT: begin
        root_d    = mem_rdata_i;
        req.re    = 1'b1;
        req.raddr = IDX_W'(count_q);
        state_d   = S_EX_LAST;
      end

      S_EX_LAST: begin
        cur_d = mem_rdata_i;
        idx_d = '0;
        if (count_q == '0) begin
          state_d = S_DONE;
        end else if (CH_W'(1) < CH_W'(count_q)) begin
          req.re    = 1'b1;
          req.raddr = IDX_W'(1);
          state_d   = S_EX_L;
        end else begin
          req.we    = 1'b1;
          req.waddr = '0;
          req.wdata = mem_rdata_i;
          state_d   = S_DONE;
        end
      end

      S_EX_L, S_EX_R: begin
        if ((state_q == S_EX_L) && (r_ch < CH_W'(count_q))) begin
          left_d    = mem_rdata_i;
          req.re    = 1'b1;
          req.raddr = r_ch[IDX_W-1:0];
          state_d   = S_EX_R;
        end else begin
          req.we    = 1'b1;
          req.waddr = idx_q;
          if (pick_l || pick_r) begin
            // The smaller child moves up; the hole sinks to its slot.
            req.wdata = c_ent;
            idx_d     = c_idx;
            if (nl_ch < CH_W'(count_q)) begin
              req.re    = 1'b1;
              req.raddr = nl_ch[IDX_W-1:0];
              state_d   = S_EX_L;
            end else begin
              state_d = S_PLACE;
            end
          end else begin
            req.wdata = cur_q;
            state_d   = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.status     = status_q;
          out_d.out_key    = root_q.key;
          out_d.out_id     = root_q.id;
          out_d.fill_level = FILL_W'(count_q);
          out_valid_d      = 1'b1;
          state_d          = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    cur_q    <= cur_d;
    left_q   <= left_d;
    root_q   <= root_d;
    status_q <= status_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign mem_req_o   = req;

endmodule
